// ----- sv/sorted_insert_time_queue_assert.svh -----
// Assertion macros shared by the sorted insert time queue modules.
`ifndef SORTED_INSERT_TIME_QUEUE_ASSERT_SVH
`define SORTED_INSERT_TIME_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define SITQ_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define SITQ_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define SITQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SITQ_ASSERT(name, clk, rst_n, prop, msg)
`define SITQ_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg)
`define SITQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- sv/sitq_pkg.sv -----
// Package with shared types and constants of the sorted insert time queue.
package sitq_pkg;

  localparam int SITQ_DEPTH     = 32;
  localparam int SITQ_KEY_WIDTH = 32;

  localparam int TIME_W   = 32;
  localparam int SVC_W    = 32;
  localparam int PASS_W   = 3;
  localparam int POS_W    = 6;
  localparam int OCC_W    = 6;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 80;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_t;

  // Commands from the sequencer to the cell row.
  typedef struct packed {
    logic load;     // capture the accepted request
    logic compare;  // register per-cell compare flags
    logic exec;     // shift the cells and form the result
  } cmd_t;

endpackage

// ----- sv/sitq_ctrl.sv -----
// Sequencer of the sorted insert time queue: handshakes and step commands.
`include "sorted_insert_time_queue_assert.svh"

module sitq_ctrl
  import sitq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  output logic out_tvalid,
  input  logic out_tready,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        // hold the step until the result register can take a new result
        if (slot_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SITQ_ASSERT_NEXT(a_accept_to_cmp, clk, rst_n, in_tvalid && in_tready, state_r == S_CMP, "accepted request did not move to compare")
  `SITQ_ASSERT_IMPLY(a_exec_slot_free, clk, rst_n, cmd.exec, !out_valid_r || out_tready, "result overwritten before it was taken")
  `SITQ_ASSERT_IMPLY(a_out_rise_from_exec, clk, rst_n, $rose(out_valid_r), $past(cmd.exec), "result valid without an execute step")

endmodule

// ----- sv/sitq_dp.sv -----
// Cell row of the sorted insert time queue: per-cell compare, shift and result.
`include "sorted_insert_time_queue_assert.svh"

module sitq_dp
  import sitq_pkg::*;
#(
  parameter int DEPTH     = SITQ_DEPTH,
  parameter int KEY_WIDTH = SITQ_KEY_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic              in_operation,
  input  logic [TIME_W-1:0] in_arrival_time,
  input  logic [SVC_W-1:0]  in_service_time,
  input  logic [PASS_W-1:0] in_pass_count,
  output status_t           res_status,
  output logic [POS_W-1:0]  res_position,
  output logic [TIME_W-1:0] res_head_time,
  output logic [SVC_W-1:0]  res_head_service,
  output logic [PASS_W-1:0] res_head_passes,
  output logic [OCC_W-1:0]  res_occupancy
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $clog2(DEPTH);

  // captured request
  logic                 op_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [SVC_W-1:0]     svc_r;
  logic [PASS_W-1:0]    pass_r;

  // cells, head at index 0
  logic [KEY_WIDTH-1:0] key_cell_r  [DEPTH];
  logic [SVC_W-1:0]     svc_cell_r  [DEPTH];
  logic [PASS_W-1:0]    pass_cell_r [DEPTH];
  logic [KEY_WIDTH-1:0] key_up  [DEPTH];
  logic [SVC_W-1:0]     svc_up  [DEPTH];
  logic [PASS_W-1:0]    pass_up [DEPTH];
  logic [KEY_WIDTH-1:0] key_dn  [DEPTH];
  logic [SVC_W-1:0]     svc_dn  [DEPTH];
  logic [PASS_W-1:0]    pass_dn [DEPTH];

  logic [DEPTH-1:0] le_r, le_nxt, prev_le, edge_hit;
  logic [CW-1:0]    count_r, count_nxt;
  logic [SW-1:0]    slot;
  logic             full, empty, do_ins, do_pop;

  status_t           status_r;
  logic [POS_W-1:0]  pos_r;
  logic [TIME_W-1:0] time_r;
  logic [SVC_W-1:0]  hsvc_r;
  logic [PASS_W-1:0] hpass_r;
  logic [OCC_W-1:0]  occ_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      key_r  <= KEY_WIDTH'(in_arrival_time);
      svc_r  <= in_service_time;
      pass_r <= in_pass_count;
    end
  end

  // a cell joins the prefix when it is occupied and its key is not above the new one
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le_nxt[i] = (CW'(i) < count_r) && (key_cell_r[i] <= key_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      le_r <= le_nxt;
    end
  end

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_ins  = cmd.exec && (op_r == OP_INSERT) && !full;
  assign do_pop  = cmd.exec && (op_r == OP_POP) && !empty;
  assign prev_le = {le_r[DEPTH-2:0], 1'b1};
  assign edge_hit = prev_le & ~le_r;

  // the prefix ends at exactly one cell: encode it
  always_comb begin
    slot = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (edge_hit[i]) begin
        slot = slot | SW'(i);
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign key_up[g]  = key_r;
      assign svc_up[g]  = svc_r;
      assign pass_up[g] = pass_r;
    end else begin : g_body
      assign key_up[g]  = key_cell_r[g-1];
      assign svc_up[g]  = svc_cell_r[g-1];
      assign pass_up[g] = pass_cell_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign key_dn[g]  = key_cell_r[g];
      assign svc_dn[g]  = svc_cell_r[g];
      assign pass_dn[g] = pass_cell_r[g];
    end else begin : g_inner
      assign key_dn[g]  = key_cell_r[g+1];
      assign svc_dn[g]  = svc_cell_r[g+1];
      assign pass_dn[g] = pass_cell_r[g+1];
    end

    always_ff @(posedge clk) begin
      if (do_ins) begin
        if (!le_r[g]) begin
          // drop the new entry at the end of the prefix, shift the rest back
          key_cell_r[g]  <= prev_le[g] ? key_r  : key_up[g];
          svc_cell_r[g]  <= prev_le[g] ? svc_r  : svc_up[g];
          pass_cell_r[g] <= prev_le[g] ? pass_r : pass_up[g];
        end
      end else if (do_pop) begin
        key_cell_r[g]  <= key_dn[g];
        svc_cell_r[g]  <= svc_dn[g];
        pass_cell_r[g] <= pass_dn[g];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= ST_OK;
      pos_r    <= '0;
      time_r   <= '0;
      hsvc_r   <= '0;
      hpass_r  <= '0;
      occ_r    <= OCC_W'(count_nxt);
      if (op_r == OP_INSERT) begin
        if (full) begin
          status_r <= ST_FULL;
        end else begin
          pos_r <= POS_W'(CW'(slot) + CW'(1));
        end
      end else begin
        if (empty) begin
          status_r <= ST_EMPTY;
        end else begin
          time_r  <= TIME_W'(key_cell_r[0]);
          hsvc_r  <= svc_cell_r[0];
          hpass_r <= pass_cell_r[0];
        end
      end
    end
  end

  assign res_status       = status_r;
  assign res_position     = pos_r;
  assign res_head_time    = time_r;
  assign res_head_service = hsvc_r;
  assign res_head_passes  = hpass_r;
  assign res_occupancy    = occ_r;

  `SITQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(DEPTH), "entry count above depth")
  `SITQ_ASSERT_IMPLY(a_head_order, clk, rst_n, count_r >= CW'(2), key_cell_r[0] <= key_cell_r[1], "head cells out of order")
  `SITQ_ASSERT_NEXT(a_insert_grows, clk, rst_n, do_ins, count_r == $past(count_r) + CW'(1), "insert did not grow the queue")

endmodule

// ----- sv/sorted_insert_time_queue.sv -----
// Top level of the sorted insert time queue: stream ports, sequencer and cell row.
//
// Bounded queue of up to DEPTH entries kept in ascending order of arrival
// time; an insert lands behind every stored entry with an equal or smaller
// key, so equal keys leave first come, first served. Each request (insert or
// pop, chosen by in_tuser) yields exactly one result carrying a status (ok,
// full, empty), the 1-based landing slot of an insert, the fields of a popped
// head, and the occupancy after the request. A request passes through capture,
// a compare step in which every cell checks its own key against the new one,
// and a shift step in which each cell takes from its neighbor. The next request
// is accepted in the cycle after the shift, so no new request enters before the
// one ahead of it has shifted; a result not taken stalls only the shift step of
// the request behind it. Position and occupancy are 6 bits wide and wrap for a
// DEPTH above 63. Only the low KEY_WIDTH bits of the arrival time are stored and
// compared. There is no clearing pass after reset; the block is ready in the
// first cycle out of reset.
module sorted_insert_time_queue
  import sitq_pkg::*;
#(
  parameter int DEPTH     = SITQ_DEPTH,
  parameter int KEY_WIDTH = SITQ_KEY_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [31:0] arrival_time, [63:32] service_time, [66:64] pass_count
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] operation
  input  logic [0:0]             in_tuser,
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [5:0] position, [37:6] head_time, [69:38] head_service,
  // [72:70] head_passes, [78:73] occupancy
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [1:0] status
  output logic [STATUS_W-1:0]    out_tuser
);

  cmd_t              cmd;
  status_t           res_status;
  logic [POS_W-1:0]  res_position;
  logic [TIME_W-1:0] res_head_time;
  logic [SVC_W-1:0]  res_head_service;
  logic [PASS_W-1:0] res_head_passes;
  logic [OCC_W-1:0]  res_occupancy;

  // sequencer: accept, compare, shift; holds the result valid flag
  sitq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // cell row with per-cell comparators, entry count and result register
  sitq_dp #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_operation     (in_tuser[0]),
    .in_arrival_time  (in_tdata[31:0]),
    .in_service_time  (in_tdata[63:32]),
    .in_pass_count    (in_tdata[66:64]),
    .res_status       (res_status),
    .res_position     (res_position),
    .res_head_time    (res_head_time),
    .res_head_service (res_head_service),
    .res_head_passes  (res_head_passes),
    .res_occupancy    (res_occupancy)
  );

  // pack the result fields, lowest field first, pad to whole bytes
  assign out_tdata = {1'b0, res_occupancy, res_head_passes, res_head_service,
                      res_head_time, res_position};
  assign out_tuser = res_status;

endmodule

// ----- tb/sorted_insert_time_queue_tb.sv -----
// Self-checking testbench of the sorted insert time queue with a built-in predictor.
`timescale 1ns / 1ps

module sorted_insert_time_queue_tb
  import sitq_pkg::*;
();

  // One request as the sender sees it, before packing onto the stream.
  typedef struct {
    op_t               op;
    logic [TIME_W-1:0] arrival;
    logic [SVC_W-1:0]  service;
    logic [PASS_W-1:0] passes;
  } request_t;

  // One result, field by field, as the block reports it.
  typedef struct {
    status_t           status;
    logic [POS_W-1:0]  slot;
    logic [TIME_W-1:0] head_time;
    logic [SVC_W-1:0]  head_service;
    logic [PASS_W-1:0] head_passes;
    logic [OCC_W-1:0]  occupancy;
  } result_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [0:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;

  sorted_insert_time_queue uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: a private copy of the sorted entries, head in slot 0.
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0] sorted_times    [SITQ_DEPTH];
  logic [SVC_W-1:0]  sorted_services [SITQ_DEPTH];
  logic [PASS_W-1:0] sorted_passes   [SITQ_DEPTH];
  int unsigned       held_entries = 0;

  // Run statistics for the closing summary.
  int unsigned n_inserted = 0, n_refused_full = 0;
  int unsigned n_popped = 0, n_refused_empty = 0, peak_held = 0;

  request_t    req_queue[$];        // requests not yet offered to the block
  result_t     pending_results[$];  // predicted results not yet returned
  request_t    on_offer;            // request currently presented on in_*
  int unsigned error_count = 0;

  // Apply one accepted request to the private queue and form its result.
  function automatic result_t apply_queue_request(request_t r);
    logic [63:0]       key_mask;
    logic [TIME_W-1:0] key;
    int unsigned       land;
    result_t           res;
    key_mask = (64'd1 << SITQ_KEY_WIDTH) - 64'd1;
    key      = r.arrival & key_mask[TIME_W-1:0];
    res.status       = ST_OK;
    res.slot         = '0;
    res.head_time    = '0;
    res.head_service = '0;
    res.head_passes  = '0;
    if (r.op == OP_INSERT) begin
      if (held_entries >= SITQ_DEPTH) begin
        // refuse the insert; nothing moves
        res.status = ST_FULL;
        n_refused_full++;
      end else begin
        // land behind every entry with an equal or smaller key
        land = 0;
        while (land < held_entries && sorted_times[land] <= key) land++;
        for (int i = held_entries; i > land; i--) begin
          sorted_times[i]    = sorted_times[i-1];
          sorted_services[i] = sorted_services[i-1];
          sorted_passes[i]   = sorted_passes[i-1];
        end
        sorted_times[land]    = key;
        sorted_services[land] = r.service;
        sorted_passes[land]   = r.passes;
        held_entries++;
        res.slot = POS_W'(land + 1);
        n_inserted++;
      end
    end else if (held_entries == 0) begin
      res.status = ST_EMPTY;
      n_refused_empty++;
    end else begin
      // hand out the head and advance the rest by one slot
      res.head_time    = sorted_times[0];
      res.head_service = sorted_services[0];
      res.head_passes  = sorted_passes[0];
      for (int i = 1; i < held_entries; i++) begin
        sorted_times[i-1]    = sorted_times[i];
        sorted_services[i-1] = sorted_services[i];
        sorted_passes[i-1]   = sorted_passes[i];
      end
      held_entries--;
      n_popped++;
    end
    if (held_entries > peak_held) peak_held = held_entries;
    res.occupancy = OCC_W'(held_entries);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_request(op_t op, logic [TIME_W-1:0] arrival,
                               logic [SVC_W-1:0] service, logic [PASS_W-1:0] passes);
    request_t r;
    r.op      = op;
    r.arrival = arrival;
    r.service = service;
    r.passes  = passes;
    req_queue.push_back(r);
  endtask

  // Pick a key: often from a small set of whole time units so that equal keys
  // collide, sometimes an extreme, otherwise any value.
  function automatic logic [TIME_W-1:0] pick_arrival();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return TIME_W'($urandom_range(0, 7)) << 16;
      4:          return '0;
      5:          return '1;
      default:    return TIME_W'($urandom);
    endcase
  endfunction

  // Add one random request; insert_pct sets the mix of inserts and pops.
  task automatic queue_random_request(int unsigned insert_pct);
    queue_request(($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_POP,
                  pick_arrival(), SVC_W'($urandom), PASS_W'($urandom_range(0, 7)));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of requests with random gaps, fed from req_queue.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      in_tuser   <= '0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else begin
      // predict the request the block just took
      if (in_tvalid && in_tready) pending_results.push_back(apply_queue_request(on_offer));
      // hold a request that is still waiting; otherwise choose what comes next
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (req_queue.size() > 0) begin
          on_offer  = req_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= IN_TDATA_W'({on_offer.passes, on_offer.service, on_offer.arrival});
          in_tuser  <= on_offer.op;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // end of burst: open a gap, or none so bursts sometimes run together
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern that switches among random modes, plus one long
  // hold-off once enough requests went in, so the block backs up and stalls
  // its input while the driver keeps offering.
  // ---------------------------------------------------------------------------
  int unsigned ready_mode = 0, mode_left = 0, hold_left = 0, seen_requests = 0;
  bit          hold_done  = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) seen_requests++;
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left  = 50;
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && seen_requests >= 120) begin
        hold_done = 1'b1;
        hold_left = 300;
        out_tready <= 1'b0;
      end else begin
        case (ready_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare every returned result with the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_field(string label, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual tuser %0h tdata %0h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("status",       32'(want.status),    32'(out_tuser));
        check_field("position",     32'(want.slot),      32'(out_tdata[5:0]));
        check_field("head_time",    want.head_time,      out_tdata[37:6]);
        check_field("head_service", want.head_service,   out_tdata[69:38]);
        check_field("head_passes",  32'(want.head_passes), 32'(out_tdata[72:70]));
        check_field("occupancy",    32'(want.occupancy), 32'(out_tdata[78:73]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned random_items, run_len, phase, insert_pct;

    // Directed part: pop while empty, key and payload extremes, equal keys
    // leaving in arrival order, a key equal to the head, then drain past empty.
    queue_request(OP_POP,    32'h0000_0000, 32'h0000_0000, 3'd0);
    queue_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000, 3'd0);
    queue_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
    queue_request(OP_INSERT, 32'h0001_8000, 32'h0000_0001, 3'd3);
    queue_request(OP_INSERT, 32'h0001_8000, 32'h0000_0002, 3'd4);
    queue_request(OP_INSERT, 32'h0001_8000, 32'h0000_0003, 3'd5);
    queue_request(OP_INSERT, 32'h0001_8000, 32'hA5A5_5A5A, 3'd6);
    queue_request(OP_INSERT, 32'h0000_0000, 32'h8000_0000, 3'd1);
    queue_request(OP_INSERT, 32'h0000_FFFF, 32'h0000_FFFF, 3'd2);
    queue_request(OP_INSERT, 32'hFFFF_FFFF, 32'h1234_5678, 3'd0);
    for (int i = 0; i < 10; i++) queue_request(OP_POP, '0, '0, '0);

    // Random part: alternate filling runs, draining runs and mixed runs so the
    // queue swings between empty and full and both refusals keep occurring.
    random_items = 0;
    phase        = 0;
    while (random_items < 360) begin
      case (phase % 3)
        0: begin run_len = $urandom_range(36, 60); insert_pct = 90; end
        1: begin run_len = $urandom_range(36, 60); insert_pct = 10; end
        default: begin run_len = $urandom_range(10, 40); insert_pct = 50; end
      endcase
      for (int i = 0; i < run_len; i++) queue_random_request(insert_pct);
      random_items += run_len;
      phase++;
    end

    // Hold reset at the start, then release it for good.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every request went in and every result came back.
    while (req_queue.size() != 0 || in_tvalid || pending_results.size() != 0)
      @(posedge clk);
    // Keep the clock running so that any stray result can still show up.
    repeat (20) @(posedge clk);

    $display("run covered %0d inserts (%0d refused as full), %0d pops (%0d refused as empty)",
             n_inserted, n_refused_full, n_popped, n_refused_empty);
    $display("peak occupancy %0d of %0d entries", peak_held, SITQ_DEPTH);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #500000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/sitq_pkg.sv
sv/sitq_ctrl.sv
sv/sitq_dp.sv
sv/sorted_insert_time_queue.sv
tb/sorted_insert_time_queue_tb.sv
